// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL that carries checks (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/chacha_pkg.sv =====
// Types, constants and helpers shared by the ChaCha20 stream cipher RTL.
package chacha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646E;
  localparam word_t SIGMA2 = 32'h7962_2D32;
  localparam word_t SIGMA3 = 32'h6B20_6574;

  localparam int DOUBLE_ROUNDS_DEF = 10;

  localparam int DATA_W  = 64;
  localparam int COUNT_W = 4;
  localparam int TDATA_W = 72;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;

  // Quarter-round step codes
  localparam logic [1:0] QR_STEP_A0 = 2'd0;
  localparam logic [1:0] QR_STEP_C0 = 2'd1;
  localparam logic [1:0] QR_STEP_A1 = 2'd2;
  localparam logic [1:0] QR_STEP_C1 = 2'd3;

  // Core status seen by the top-level sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  // Rotate left by the amount tied to the quarter-round step
  function automatic word_t qr_rotl(input word_t v, input logic [1:0] step);
    word_t r;
    case (step)
      QR_STEP_A0: r = {v[15:0], v[31:16]};
      QR_STEP_C0: r = {v[19:0], v[31:20]};
      QR_STEP_A1: r = {v[23:0], v[31:24]};
      default:    r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/chacha_core.sv =====
// ChaCha20 block core: four quarter-round lanes, one step per cycle, plus feed-forward.
module chacha_core #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  chacha_pkg::state_t         init_i,
  input  logic [2:0]                 pos_i,
  output logic [63:0]                ks_o,
  output chacha_pkg::core_status_t   status_o
);

  localparam int ROUND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  typedef enum logic [2:0] {
    CR_IDLE  = 3'b001,
    CR_ROUND = 3'b010,
    CR_FEED  = 3'b100
  } core_state_t;

  core_state_t          state_r, state_nxt;
  chacha_pkg::state_t   work_r, work_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 half_r, half_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic                 last_step;

  assign last_step = (step_r == chacha_pkg::QR_STEP_C1) && half_r &&
                     (round_r == ROUND_W'(DOUBLE_ROUNDS - 1));

  // Lane datapath; rows are shifted after each half round so diagonals line up as columns
  always_comb begin
    chacha_pkg::state_t w;
    chacha_pkg::word_t  x, y, z, sum;
    w = work_r;
    for (int l = 0; l < 4; l++) begin
      if (!step_r[0]) begin
        x = work_r[l];
        y = work_r[4 + l];
        z = work_r[12 + l];
      end else begin
        x = work_r[8 + l];
        y = work_r[12 + l];
        z = work_r[4 + l];
      end
      sum = x + y;
      if (!step_r[0]) begin
        w[l]      = sum;
        w[12 + l] = chacha_pkg::qr_rotl(z ^ sum, step_r);
      end else begin
        w[8 + l]  = sum;
        w[4 + l]  = chacha_pkg::qr_rotl(z ^ sum, step_r);
      end
    end
    work_nxt = w;
    if (step_r == chacha_pkg::QR_STEP_C1) begin
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 4; i++) begin
          if (!half_r) begin
            work_nxt[4 * r + i] = w[4 * r + ((i + r) % 4)];
          end else begin
            work_nxt[4 * r + i] = w[4 * r + ((i - r + 4) % 4)];
          end
        end
      end
    end
    if (state_r == CR_FEED) begin
      for (int i = 0; i < 16; i++) begin
        work_nxt[i] = work_r[i] + init_i[i];
      end
    end else if (state_r == CR_IDLE) begin
      work_nxt = start_i ? init_i : work_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    half_nxt  = half_r;
    round_nxt = round_r;
    unique case (state_r)
      CR_IDLE: begin
        if (start_i) begin
          state_nxt = CR_ROUND;
          step_nxt  = chacha_pkg::QR_STEP_A0;
          half_nxt  = 1'b0;
          round_nxt = '0;
        end
      end
      CR_ROUND: begin
        step_nxt = step_r + 2'd1;
        if (step_r == chacha_pkg::QR_STEP_C1) begin
          half_nxt = ~half_r;
          if (half_r) begin
            round_nxt = round_r + ROUND_W'(1);
          end
        end
        if (last_step) begin
          state_nxt = CR_FEED;
        end
      end
      CR_FEED: begin
        state_nxt = CR_IDLE;
      end
      default: state_nxt = CR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CR_IDLE;
      step_r  <= '0;
      half_r  <= 1'b0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      half_r  <= half_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign ks_o = {work_r[{pos_i, 1'b1}], work_r[{pos_i, 1'b0}]};
  assign status_o.busy = (state_r != CR_IDLE);
  assign status_o.done = (state_r == CR_FEED);

endmodule

// ===== sv/chacha20_stream_cipher_top.sv =====
// ChaCha20 stream cipher top level: configuration, block sequencing and output register.
//
//  Channel | Ports                                   | Contents
//  --------+-----------------------------------------+------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata/in_tlast   | data_in, byte_count; tlast = call_end
//  output  | out_tvalid/out_tready/out_tdata/out_tlast| data_out, byte_count_out; tlast = call end or short item
//  config  | cfg_valid/cfg_ready/cfg_index/cfg_data  | register index 0..5, write data
//
// An item that finds a keystream block held is accepted in S_IDLE, then its result is loaded in S_OUT.
// An item that needs a new block passes through S_ROUND first, while the core runs DOUBLE_ROUNDS double rounds:
// the core runs one quarter-round step on four lanes per cycle, then a feed-forward step.
// A result waits in the output register while the next transaction is accepted; only the
// result load stalls on out_tready. Reset (rst_n low, synchronous) clears the counter,
// the held-block flag, the keystream position and all configuration registers.
`include "assert_macros.svh"

module chacha20_stream_cipher_top #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [chacha_pkg::TDATA_W-1:0]     in_tdata,   // [63:0] data_in, [67:64] byte_count
  input  logic                               in_tlast,   // call_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [chacha_pkg::TDATA_W-1:0]     out_tdata,  // [63:0] data_out, [67:64] byte_count_out
  output logic                               out_tlast,  // call_end_out
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_OUT   = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  // configuration
  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_lo_r;
  logic [31:0]      nonce_hi_r;

  // stream state
  logic [31:0] counter_r, counter_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        block_valid_r, block_valid_nxt;

  // captured item
  logic [63:0] din_r;
  logic [3:0]  cnt_r;
  logic        end_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] dout_r;
  logic [3:0]  cnt_out_r;
  logic        end_out_r;

  logic                     in_fire, out_load, start;
  logic [3:0]               in_cnt_eff, cnt_eff;
  logic                     ends;
  logic [63:0]              ks, mask, result;
  chacha_pkg::state_t       init;
  chacha_pkg::core_status_t core_st;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // counts above eight act as eight
  assign in_cnt_eff = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
  assign cnt_eff    = (cnt_r > 4'd8) ? 4'd8 : cnt_r;
  assign ends       = end_r || (cnt_eff < 4'd8);
  assign start      = in_fire && (in_cnt_eff != 4'd0) && !block_valid_r;

  // initial block state from key, counter and nonce
  always_comb begin
    init[0] = chacha_pkg::SIGMA0;
    init[1] = chacha_pkg::SIGMA1;
    init[2] = chacha_pkg::SIGMA2;
    init[3] = chacha_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_r[i][31:0];
      init[5 + 2 * i] = key_r[i][63:32];
    end
    init[12] = counter_r;
    init[13] = nonce_lo_r[31:0];
    init[14] = nonce_lo_r[63:32];
    init[15] = nonce_hi_r;
  end

  chacha_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .init_i   (init),
    .pos_i    (pos_r),
    .ks_o     (ks),
    .status_o (core_st)
  );

  // byte mask over the valid low bytes
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8 * b +: 8] = (4'(b) < cnt_eff) ? 8'hFF : 8'h00;
    end
  end
  assign result = din_r ^ (ks & mask);

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt       = state_r;
    counter_nxt     = counter_r;
    pos_nxt         = pos_r;
    block_valid_nxt = block_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = start ? S_ROUND : S_OUT;
        end
      end
      S_ROUND: begin
        if (core_st.done) begin
          counter_nxt     = counter_r + 32'd1;
          block_valid_nxt = 1'b1;
          pos_nxt         = 3'd0;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
          if (cnt_eff != 4'd0) begin
            pos_nxt = pos_r + 3'd1;
            if (pos_r == 3'd7) begin
              block_valid_nxt = 1'b0;
            end
          end
          // a call end, or an item of fewer than eight bytes, drops whatever is left of the block
          if (ends) begin
            block_valid_nxt = 1'b0;
            pos_nxt         = 3'd0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      counter_r     <= '0;
      pos_r         <= '0;
      block_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      key_r         <= '0;
      nonce_lo_r    <= '0;
      nonce_hi_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      counter_r     <= counter_nxt;
      pos_r         <= pos_nxt;
      block_valid_r <= block_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          chacha_pkg::CFG_KEY0:     key_r[0]   <= cfg_data;
          chacha_pkg::CFG_KEY1:     key_r[1]   <= cfg_data;
          chacha_pkg::CFG_KEY2:     key_r[2]   <= cfg_data;
          chacha_pkg::CFG_KEY3:     key_r[3]   <= cfg_data;
          chacha_pkg::CFG_NONCE_LO: nonce_lo_r <= cfg_data;
          chacha_pkg::CFG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      din_r <= in_tdata[63:0];
      cnt_r <= in_tdata[67:64];
      end_r <= in_tlast;
    end
    if (out_load) begin
      dout_r    <= result;
      cnt_out_r <= cnt_r;
      end_out_r <= ends;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, cnt_out_r, dout_r};
  assign out_tlast  = end_out_r;

  // checks
  `ASSERT_IMPL(a_ready_core_idle, in_tready, !core_st.busy, "input ready while core busy")
  `ASSERT_NEXT(a_start_busy, start, core_st.busy, "core did not start on block request")
  `ASSERT_NEXT(a_done_block, core_st.done, block_valid_r && (pos_r == 3'd0),
               "finished block not marked held at word zero")
  `ASSERT_IMPL(a_load_state, out_load, state_r == S_OUT, "result loaded outside result state")

endmodule
